FILE: hdl/hbs_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the heightmap bilinear sampler.
// No dependencies; every other file refers to it by scoped names.
package hbs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_PLANES  = 4;
    localparam int FRAC_BITS   = 12;
    localparam int FRAC_ONE    = 1 << FRAC_BITS;

    localparam int STORE_DEPTH = MAX_PLANES * (MAX_COLUMNS + 1) * (MAX_ROWS + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int PLC_W       = $clog2(MAX_PLANES + 1);
    localparam int CH_W        = $clog2(MAX_ROWS + 2);
    localparam int STRIDE_W    = $clog2((MAX_COLUMNS + 1) * (MAX_ROWS + 1) + 1);
    localparam int AREA_W      = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
    localparam int LXR_W       = COL_W + ROW_W;

    localparam int PLANE_W     = 2;
    localparam int POS_W       = 16;
    localparam int FRAC_W      = 13;
    localparam int SXY_W       = 7;
    localparam int VALUE_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int HEIGHT_W    = 16;
    localparam int TIDX_W      = 14;
    localparam int ORIGIN_W    = 15;
    localparam int COUNT_W     = 7;
    localparam int PCOUNT_W    = 3;
    localparam int DIFF_W      = POS_W + 2;
    localparam int PROD_W      = HEIGHT_W + 1 + FRAC_W + 1;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT  = 3'd4;

    localparam logic [1:0] CORNER_SW = 2'd0;
    localparam logic [1:0] CORNER_SE = 2'd1;
    localparam logic [1:0] CORNER_NE = 2'd2;
    localparam logic [1:0] CORNER_NW = 2'd3;

    localparam logic [1:0] LSTEP_SOUTH = 2'd0;
    localparam logic [1:0] LSTEP_NORTH = 2'd1;
    localparam logic [1:0] LSTEP_FINAL = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_POS_OUT    = 2'd1,
        ST_FRAC_HIGH  = 2'd2,
        ST_CORNER_OUT = 2'd3
    } t_status;

    typedef struct packed {
        t_op                        op;
        t_status                    status;
        logic [ADDR_W-1:0]          addr;
        logic [CH_W-1:0]            ch;
        logic [FRAC_W-1:0]          frac_x;
        logic [FRAC_W-1:0]          frac_y;
        logic signed [VALUE_W-1:0]  value;
        logic [TIDX_W-1:0]          tidx;
    } t_job;

    function automatic logic [31:0] clamp_count(input logic [31:0] v, input int hi);
        logic [31:0] r;
        r = v;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > 32'(hi)) begin
            r = 32'(hi);
        end
        return r;
    endfunction

endpackage

FILE: hdl/hbs_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, input register, bounds checks and
// address / tile index generation. Depends on hbs_pkg.
module hbs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op,
    input  logic [hbs_pkg::PLANE_W-1:0]      i_plane,
    input  logic [hbs_pkg::POS_W-1:0]        i_pos_x,
    input  logic [hbs_pkg::POS_W-1:0]        i_pos_y,
    input  logic [hbs_pkg::FRAC_W-1:0]       i_frac_x,
    input  logic [hbs_pkg::FRAC_W-1:0]       i_frac_y,
    input  logic [hbs_pkg::SXY_W-1:0]        i_sample_x,
    input  logic [hbs_pkg::SXY_W-1:0]        i_sample_y,
    input  logic [hbs_pkg::VALUE_W-1:0]      i_sample_value,
    output logic                             o_push,
    output hbs_pkg::t_job                    o_job,
    input  logic                             i_full
);

    typedef struct packed {
        hbs_pkg::t_op                      op;
        logic [hbs_pkg::PLANE_W-1:0]       plane;
        logic signed [hbs_pkg::POS_W-1:0]  pos_x;
        logic signed [hbs_pkg::POS_W-1:0]  pos_y;
        logic [hbs_pkg::FRAC_W-1:0]        frac_x;
        logic [hbs_pkg::FRAC_W-1:0]        frac_y;
        logic [hbs_pkg::SXY_W-1:0]         sample_x;
        logic [hbs_pkg::SXY_W-1:0]         sample_y;
        logic [hbs_pkg::VALUE_W-1:0]       value;
    } t_item;

    typedef struct packed {
        hbs_pkg::t_op                      op;
        hbs_pkg::t_status                  status;
        logic [hbs_pkg::COL_W-1:0]         lx;
        logic [hbs_pkg::ROW_W-1:0]         ly;
        logic [hbs_pkg::ADDR_W-1:0]        ps;
        logic [hbs_pkg::TIDX_W-1:0]        pa;
        logic [hbs_pkg::FRAC_W-1:0]        frac_x;
        logic [hbs_pkg::FRAC_W-1:0]        frac_y;
        logic [hbs_pkg::VALUE_W-1:0]       value;
    } t_cls;

    logic signed [hbs_pkg::ORIGIN_W-1:0]  r_origin_x;
    logic signed [hbs_pkg::ORIGIN_W-1:0]  r_origin_y;
    logic [hbs_pkg::COUNT_W-1:0]          r_tile_columns;
    logic [hbs_pkg::COUNT_W-1:0]          r_tile_rows;
    logic [hbs_pkg::PCOUNT_W-1:0]         r_plane_count;
    logic [hbs_pkg::STRIDE_W-1:0]         r_stride;
    logic [hbs_pkg::AREA_W-1:0]           r_area;

    logic [hbs_pkg::COL_W-1:0]            cols;
    logic [hbs_pkg::ROW_W-1:0]            rows;
    logic [hbs_pkg::PLC_W-1:0]            planes;

    logic                                 r_in_v;
    t_item                                r_in;
    logic                                 r_cls_v;
    t_cls                                 r_cls;
    t_cls                                 n_cls;

    logic                                 adv_in;
    logic                                 adv_cls;
    logic signed [hbs_pkg::DIFF_W-1:0]    diff_x;
    logic signed [hbs_pkg::DIFF_W-1:0]    diff_y;
    logic                                 plane_bad;
    logic [hbs_pkg::LXR_W-1:0]            lxr;

    assign cols   = hbs_pkg::COL_W'(hbs_pkg::clamp_count(32'(r_tile_columns),
                                                         hbs_pkg::MAX_COLUMNS));
    assign rows   = hbs_pkg::ROW_W'(hbs_pkg::clamp_count(32'(r_tile_rows),
                                                         hbs_pkg::MAX_ROWS));
    assign planes = hbs_pkg::PLC_W'(hbs_pkg::clamp_count(32'(r_plane_count),
                                                         hbs_pkg::MAX_PLANES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_tile_columns <= hbs_pkg::COUNT_W'(64);
            r_tile_rows    <= hbs_pkg::COUNT_W'(64);
            r_plane_count  <= hbs_pkg::PCOUNT_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbs_pkg::CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data;
                hbs_pkg::CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data;
                hbs_pkg::CFG_TILE_COLUMNS: r_tile_columns <= i_cfg_data[hbs_pkg::COUNT_W-1:0];
                hbs_pkg::CFG_TILE_ROWS:    r_tile_rows    <= i_cfg_data[hbs_pkg::COUNT_W-1:0];
                hbs_pkg::CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data[hbs_pkg::PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_stride <= hbs_pkg::STRIDE_W'((32'(cols) + 32'd1) * (32'(rows) + 32'd1));
        r_area   <= hbs_pkg::AREA_W'(32'(cols) * 32'(rows));
    end

    assign adv_cls = r_cls_v && !i_full;
    assign adv_in  = r_in_v && (!r_cls_v || adv_cls);
    assign o_ready = !r_in_v || adv_in;

    always_comb begin
        diff_x = hbs_pkg::DIFF_W'(r_in.pos_x) - hbs_pkg::DIFF_W'(r_origin_x);
        diff_y = hbs_pkg::DIFF_W'(r_in.pos_y) - hbs_pkg::DIFF_W'(r_origin_y);
        plane_bad = 32'(r_in.plane) >= 32'(planes);

        n_cls        = '0;
        n_cls.op     = r_in.op;
        n_cls.status = hbs_pkg::ST_OK;
        n_cls.ps     = hbs_pkg::ADDR_W'(hbs_pkg::ADDR_W'(r_in.plane) *
                                        hbs_pkg::ADDR_W'(r_stride));
        n_cls.pa     = hbs_pkg::TIDX_W'(hbs_pkg::TIDX_W'(r_in.plane) *
                                        hbs_pkg::TIDX_W'(r_area));
        n_cls.frac_x = r_in.frac_x;
        n_cls.frac_y = r_in.frac_y;
        n_cls.value  = r_in.value;
        if (r_in.op == hbs_pkg::OP_WRITE) begin
            n_cls.lx = hbs_pkg::COL_W'(r_in.sample_x);
            n_cls.ly = hbs_pkg::ROW_W'(r_in.sample_y);
            if (plane_bad || 32'(r_in.sample_x) > 32'(cols) ||
                32'(r_in.sample_y) > 32'(rows)) begin
                n_cls.status = hbs_pkg::ST_CORNER_OUT;
            end
        end else begin
            n_cls.lx = hbs_pkg::COL_W'(diff_x);
            n_cls.ly = hbs_pkg::ROW_W'(diff_y);
            if (32'(r_in.frac_x) > 32'(hbs_pkg::FRAC_ONE) ||
                32'(r_in.frac_y) > 32'(hbs_pkg::FRAC_ONE)) begin
                n_cls.status = hbs_pkg::ST_FRAC_HIGH;
            end else if (plane_bad || diff_x < 0 || diff_y < 0 ||
                         diff_x >= $signed(hbs_pkg::DIFF_W'(cols)) ||
                         diff_y >= $signed(hbs_pkg::DIFF_W'(rows))) begin
                n_cls.status = hbs_pkg::ST_POS_OUT;
            end
        end
    end

    always_comb begin
        lxr          = hbs_pkg::LXR_W'(r_cls.lx) * hbs_pkg::LXR_W'(rows);
        o_push       = adv_cls;
        o_job.op     = r_cls.op;
        o_job.status = r_cls.status;
        o_job.addr   = r_cls.ps + hbs_pkg::ADDR_W'(lxr) + hbs_pkg::ADDR_W'(r_cls.lx) +
                       hbs_pkg::ADDR_W'(r_cls.ly);
        o_job.ch     = hbs_pkg::CH_W'(32'(rows) + 32'd1);
        o_job.frac_x = r_cls.frac_x;
        o_job.frac_y = r_cls.frac_y;
        o_job.value  = r_cls.value;
        o_job.tidx   = hbs_pkg::TIDX_W'(32'(r_cls.pa) + 32'(lxr) + 32'(r_cls.ly));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_cls_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_v <= i_valid;
            end
            if (adv_in) begin
                r_cls_v <= 1'b1;
            end else if (adv_cls) begin
                r_cls_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.op       <= hbs_pkg::t_op'(i_op);
            r_in.plane    <= i_plane;
            r_in.pos_x    <= i_pos_x;
            r_in.pos_y    <= i_pos_y;
            r_in.frac_x   <= i_frac_x;
            r_in.frac_y   <= i_frac_y;
            r_in.sample_x <= i_sample_x;
            r_in.sample_y <= i_sample_y;
            r_in.value    <= i_sample_value;
        end
        if (adv_in) begin
            r_cls <= n_cls;
        end
    end

endmodule

FILE: hdl/hbs_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the interpolation back end.
// Depends on hbs_pkg for the job type and depth.
module hbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hbs_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hbs_pkg::t_job  o_job
);

    hbs_pkg::t_job                r_slot [hbs_pkg::QUEUE_DEPTH];
    logic [hbs_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [hbs_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [hbs_pkg::QCNT_W-1:0]   r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = r_count == hbs_pkg::QCNT_W'(hbs_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == hbs_pkg::QPTR_W'(hbs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == hbs_pkg::QPTR_W'(hbs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: hdl/hbs_back.sv
`timescale 1ns / 1ps
// Back end: height store, corner read sequencer, shared lerp unit and
// output register. Depends on hbs_pkg.
module hbs_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  hbs_pkg::t_job                   i_job,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [hbs_pkg::STATUS_W-1:0]    o_status,
    output logic [hbs_pkg::HEIGHT_W-1:0]    o_height,
    output logic [hbs_pkg::TIDX_W-1:0]      o_tile_index
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_WAIT = 6'b000100,
        S_MUL  = 6'b001000,
        S_ADD  = 6'b010000,
        S_DONE = 6'b100000
    } t_bstate;

    t_bstate                               r_state;
    t_bstate                               n_state;
    hbs_pkg::t_job                         r_job;
    logic [1:0]                            r_cnt;
    logic [1:0]                            r_lstep;
    logic                                  r_cap_v;
    logic [1:0]                            r_cap_sel;

    logic [hbs_pkg::VALUE_W-1:0]           r_mem [hbs_pkg::STORE_DEPTH];
    logic signed [hbs_pkg::HEIGHT_W-1:0]   r_q;
    logic signed [hbs_pkg::HEIGHT_W-1:0]   r_cnr [4];

    logic signed [hbs_pkg::HEIGHT_W-1:0]   r_la;
    logic signed [hbs_pkg::PROD_W-1:0]     r_prod;
    logic signed [hbs_pkg::HEIGHT_W-1:0]   r_south;
    logic signed [hbs_pkg::HEIGHT_W-1:0]   r_north;
    logic signed [hbs_pkg::HEIGHT_W-1:0]   r_height;

    logic                                  r_out_v;
    logic [hbs_pkg::STATUS_W-1:0]          r_out_status;
    logic [hbs_pkg::HEIGHT_W-1:0]          r_out_height;
    logic [hbs_pkg::TIDX_W-1:0]            r_out_tidx;

    logic                                  mem_we;
    logic [hbs_pkg::ADDR_W-1:0]            mem_addr;
    logic [hbs_pkg::ADDR_W-1:0]            offset;
    logic signed [hbs_pkg::HEIGHT_W-1:0]   la;
    logic signed [hbs_pkg::HEIGHT_W-1:0]   lb;
    logic [hbs_pkg::FRAC_W-1:0]            lf;
    logic signed [hbs_pkg::HEIGHT_W:0]     ldiff;
    logic signed [hbs_pkg::PROD_W-1:0]     lshift;
    logic signed [hbs_pkg::HEIGHT_W-1:0]   lres;
    logic                                  load_out;
    logic                                  good_query;

    assign good_query = (r_job.op == hbs_pkg::OP_QUERY) && (r_job.status == hbs_pkg::ST_OK);
    assign load_out   = (r_state == S_DONE) && (!r_out_v || i_tready);
    assign o_pop      = (r_state == S_IDLE) && i_job_valid;
    assign mem_we     = o_pop && (i_job.op == hbs_pkg::OP_WRITE) &&
                        (i_job.status == hbs_pkg::ST_OK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.op == hbs_pkg::OP_QUERY &&
                               i_job.status == hbs_pkg::ST_OK) ? S_RD : S_DONE;
                end
            end
            S_RD:   if (r_cnt == hbs_pkg::CORNER_NW) n_state = S_WAIT;
            S_WAIT: n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = (r_lstep == hbs_pkg::LSTEP_FINAL) ? S_DONE : S_MUL;
            S_DONE: if (!r_out_v || i_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_cnt)
            hbs_pkg::CORNER_SW: offset = '0;
            hbs_pkg::CORNER_SE: offset = hbs_pkg::ADDR_W'(r_job.ch);
            hbs_pkg::CORNER_NE: offset = hbs_pkg::ADDR_W'(r_job.ch) + 1'b1;
            default:            offset = hbs_pkg::ADDR_W'(1);
        endcase
        mem_addr = (r_state == S_IDLE) ? i_job.addr : r_job.addr + offset;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_job.value;
        end
        r_q <= r_mem[mem_addr];
    end

    always_comb begin
        case (r_lstep)
            hbs_pkg::LSTEP_SOUTH: begin
                la = r_cnr[hbs_pkg::CORNER_SW];
                lb = r_cnr[hbs_pkg::CORNER_SE];
                lf = r_job.frac_x;
            end
            hbs_pkg::LSTEP_NORTH: begin
                la = r_cnr[hbs_pkg::CORNER_NW];
                lb = r_cnr[hbs_pkg::CORNER_NE];
                lf = r_job.frac_x;
            end
            default: begin
                la = r_south;
                lb = r_north;
                lf = r_job.frac_y;
            end
        endcase
        ldiff  = (hbs_pkg::HEIGHT_W + 1)'(lb) - (hbs_pkg::HEIGHT_W + 1)'(la);
        lshift = r_prod >>> hbs_pkg::FRAC_BITS;
        lres   = r_la + lshift[hbs_pkg::HEIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_lstep <= '0;
            r_cap_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap_v <= (r_state == S_RD);
            if (o_pop) begin
                r_cnt   <= '0;
                r_lstep <= hbs_pkg::LSTEP_SOUTH;
            end else begin
                if (r_state == S_RD) r_cnt <= r_cnt + 1'b1;
                if (r_state == S_ADD) r_lstep <= r_lstep + 1'b1;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        r_cap_sel <= r_cnt;
        if (r_cap_v) begin
            r_cnr[r_cap_sel] <= r_q;
        end
        if (r_state == S_MUL) begin
            r_la   <= la;
            r_prod <= hbs_pkg::PROD_W'(ldiff) *
                      $signed(hbs_pkg::PROD_W'({1'b0, lf}));
        end
        if (r_state == S_ADD) begin
            case (r_lstep)
                hbs_pkg::LSTEP_SOUTH: r_south  <= lres;
                hbs_pkg::LSTEP_NORTH: r_north  <= lres;
                default:              r_height <= lres;
            endcase
        end
        if (load_out) begin
            r_out_status <= r_job.status;
            r_out_height <= good_query ? r_height : '0;
            r_out_tidx   <= good_query ? r_job.tidx : '0;
        end
    end

    assign o_tvalid     = r_out_v;
    assign o_status     = r_out_status;
    assign o_height     = r_out_height;
    assign o_tile_index = r_out_tidx;

endmodule

FILE: hdl/heightmap_bilinear_sampler_unit.sv
`timescale 1ns / 1ps
// The back end takes a new job only once it is done with the last one, set by the four corner
// reads through the single-port height store and the shared lerp multiplier.
// Reset (i_rst_n, synchronous, active low): clears control and queue, loads register
// defaults; the height store is not cleared and no clearing pass runs.
// Top level of the heightmap bilinear sampler; uses hbs_pkg, hbs_front, hbs_queue, hbs_back.
module heightmap_bilinear_sampler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // plane, pos_x, pos_y, frac_x, frac_y, sample_x, sample_y, sample_value, zero pad
    input  logic [hbs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status, height, tile_index
    output logic [hbs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic           push;
    logic           full;
    logic           pop;
    logic           job_valid;
    hbs_pkg::t_job  front_job;
    hbs_pkg::t_job  head_job;
    logic [hbs_pkg::STATUS_W-1:0]  status;
    logic [hbs_pkg::HEIGHT_W-1:0]  height;
    logic [hbs_pkg::TIDX_W-1:0]    tile_index;

    hbs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_op           (s_axis_tuser),
        .i_plane        (s_axis_tdata[1:0]),
        .i_pos_x        (s_axis_tdata[17:2]),
        .i_pos_y        (s_axis_tdata[33:18]),
        .i_frac_x       (s_axis_tdata[46:34]),
        .i_frac_y       (s_axis_tdata[59:47]),
        .i_sample_x     (s_axis_tdata[66:60]),
        .i_sample_y     (s_axis_tdata[73:67]),
        .i_sample_value (s_axis_tdata[89:74]),
        .o_push         (push),
        .o_job          (front_job),
        .i_full         (full)
    );

    hbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    hbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_status     (status),
        .o_height     (height),
        .o_tile_index (tile_index)
    );

    assign m_axis_tdata = {tile_index, height, status};

endmodule

FILE: hdl/hbs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the heightmap bilinear sampler, bound to the top level.
// Depends on hbs_pkg for status codes.
module hbs_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [hbs_pkg::OUT_TDATA_W-1:0]    i_m_tdata
);

    logic [hbs_pkg::STATUS_W-1:0] status;
    assign status = i_m_tdata[1:0];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output word changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (status == hbs_pkg::ST_POS_OUT || status == hbs_pkg::ST_FRAC_HIGH ||
                       status == hbs_pkg::ST_CORNER_OUT)
        |-> i_m_tdata[31:2] == '0)
        else $error("error word carries height or tile index");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

FILE: dv/tb_heightmap_bilinear_sampler_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for heightmap_bilinear_sampler_unit: drives sample writes and
// height queries, predicts each result word in a scoreboard class. Depends on hbs_pkg.
module tb_heightmap_bilinear_sampler_unit;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [hbs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    typedef struct packed {
        logic [5:0]         pad;
        logic signed [15:0] value;
        logic [6:0]         sy;
        logic [6:0]         sx;
        logic [12:0]        fy;
        logic [12:0]        fx;
        logic signed [15:0] py;
        logic signed [15:0] px;
        logic [1:0]         plane;
    } t_in_word;

    typedef struct packed {
        logic [13:0]        tile_index;
        logic signed [15:0] height;
        hbs_pkg::t_status   status;
    } t_out_word;

    class sampler_scoreboard;
        int org_x, org_y, col_reg, row_reg, plane_reg;
        logic signed [15:0] heights [hbs_pkg::STORE_DEPTH];
        bit written [hbs_pkg::STORE_DEPTH];
        t_out_word awaited_results [$];
        int mismatches, checked;
        int status_seen [4];

        function new();
            org_x = 0;
            org_y = 0;
            col_reg = 64;
            row_reg = 64;
            plane_reg = 4;
        endfunction

        function int clamp_to(int v, int hi);
            return (v < 1) ? 1 : ((v > hi) ? hi : v);
        endfunction

        function int cols_now();
            return clamp_to(col_reg, hbs_pkg::MAX_COLUMNS);
        endfunction

        function int rows_now();
            return clamp_to(row_reg, hbs_pkg::MAX_ROWS);
        endfunction

        function int planes_now();
            return clamp_to(plane_reg, hbs_pkg::MAX_PLANES);
        endfunction

        function int slot(int p, int x, int y);
            return p * (cols_now() + 1) * (rows_now() + 1) + x * (rows_now() + 1) + y;
        endfunction

        function void set_reg(logic [hbs_pkg::CFG_IDX_W-1:0] idx,
                              logic [hbs_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                hbs_pkg::CFG_ORIGIN_X:     org_x = $signed(d);
                hbs_pkg::CFG_ORIGIN_Y:     org_y = $signed(d);
                hbs_pkg::CFG_TILE_COLUMNS: col_reg = d[6:0];
                hbs_pkg::CFG_TILE_ROWS:    row_reg = d[6:0];
                hbs_pkg::CFG_PLANE_COUNT:  plane_reg = d[2:0];
                default: ;
            endcase
        endfunction

        function bit frac_high(int fx, int fy);
            return (fx > hbs_pkg::FRAC_ONE) || (fy > hbs_pkg::FRAC_ONE);
        endfunction

        function bit inside_grid(int p, int px, int py);
            return p < planes_now() && px >= org_x && py >= org_y &&
                   px < org_x + cols_now() && py < org_y + rows_now();
        endfunction

        function longint blend(longint a, longint b, longint f);
            longint prod;
            prod = (b - a) * f;
            return a + (prod >>> hbs_pkg::FRAC_BITS);
        endfunction

        function t_out_word compute_result(hbs_pkg::t_op op, t_in_word w);
            t_out_word r;
            int px, py, fx, fy, lx, ly, p;
            longint sw, se, ne, nw, south, north;
            r = '0;
            p = w.plane;
            px = $signed(w.px);
            py = $signed(w.py);
            fx = w.fx;
            fy = w.fy;
            if (op == hbs_pkg::OP_WRITE) begin
                if (p >= planes_now() || w.sx > cols_now() || w.sy > rows_now()) begin
                    r.status = hbs_pkg::ST_CORNER_OUT;
                end else begin
                    heights[slot(p, w.sx, w.sy)] = w.value;
                    written[slot(p, w.sx, w.sy)] = 1'b1;
                    r.status = hbs_pkg::ST_OK;
                end
            end else if (frac_high(fx, fy)) begin
                r.status = hbs_pkg::ST_FRAC_HIGH;
            end else if (!inside_grid(p, px, py)) begin
                r.status = hbs_pkg::ST_POS_OUT;
            end else begin
                lx = px - org_x;
                ly = py - org_y;
                sw = heights[slot(p, lx, ly)];
                se = heights[slot(p, lx + 1, ly)];
                ne = heights[slot(p, lx + 1, ly + 1)];
                nw = heights[slot(p, lx, ly + 1)];
                south = blend(sw, se, fx);
                north = blend(nw, ne, fx);
                r.status = hbs_pkg::ST_OK;
                r.height = 16'(blend(south, north, fy));
                r.tile_index = 14'(p * cols_now() * rows_now() + lx * rows_now() + ly);
            end
            return r;
        endfunction

        function void note_word(hbs_pkg::t_op op, t_in_word w);
            awaited_results.push_back(compute_result(op, w));
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            checked++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word status=%0d height=%0d index=%0d",
                             got.status, got.height, got.tile_index);
                return;
            end
            want = awaited_results.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status || got.height !== want.height ||
                got.tile_index !== want.tile_index) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: word %0d exp status=%0d height=%0d index=%0d, got %0d %0d %0d",
                             checked, want.status, want.height, want.tile_index,
                             got.status, got.height, got.tile_index);
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [hbs_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [hbs_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [hbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    sampler_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int words_sent = 0;
    int writes_sent = 0;
    int cycles = 0;

    heightmap_bilinear_sampler_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= (rx_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(t_out_word'(m_axis_tdata));
    end

    task automatic send_word(hbs_pkg::t_op op, t_in_word w);
        @(negedge i_clk);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, w);
        words_sent++;
        if (op == hbs_pkg::OP_WRITE)
            writes_sent++;
    endtask

    task automatic send_write(int p, int x, int y, int v);
        t_in_word w;
        w = {$urandom, $urandom, $urandom};
        w.pad = '0;
        w.plane = p[1:0];
        w.sx = x[6:0];
        w.sy = y[6:0];
        w.value = v[15:0];
        send_word(hbs_pkg::OP_WRITE, w);
    endtask

    // fill any corner of the tile not yet holding a sample before reading it
    task automatic send_query(int p, int px, int py, int fx, int fy);
        t_in_word w;
        int lx, ly;
        p = p & 3;
        if (!sb.frac_high(fx, fy) && sb.inside_grid(p, px, py)) begin
            lx = px - sb.org_x;
            ly = py - sb.org_y;
            for (int c = 0; c < 4; c++) begin
                if (!sb.written[sb.slot(p, lx + (c & 1), ly + (c >> 1))])
                    send_write(p, lx + (c & 1), ly + (c >> 1), $urandom);
            end
        end
        w = {$urandom, $urandom, $urandom};
        w.pad = '0;
        w.plane = p[1:0];
        w.px = px[15:0];
        w.py = py[15:0];
        w.fx = fx[12:0];
        w.fy = fy[12:0];
        send_word(hbs_pkg::OP_QUERY, w);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [hbs_pkg::CFG_IDX_W-1:0] idx, int d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d[hbs_pkg::CFG_DATA_W-1:0];
        sb.set_reg(idx, d[hbs_pkg::CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_geometry(int ox, int oy, int cols, int rows, int planes);
        write_reg(hbs_pkg::CFG_ORIGIN_X, ox);
        write_reg(hbs_pkg::CFG_ORIGIN_Y, oy);
        write_reg(hbs_pkg::CFG_TILE_COLUMNS, cols);
        write_reg(hbs_pkg::CFG_TILE_ROWS, rows);
        write_reg(hbs_pkg::CFG_PLANE_COUNT, planes);
    endtask

    function automatic int pick_frac();
        int r;
        r = $urandom_range(99);
        return (r < 10) ? 0 : ((r < 20) ? hbs_pkg::FRAC_ONE :
                               $urandom_range(hbs_pkg::FRAC_ONE));
    endfunction

    task automatic run_random(int count, bit pause_midway);
        int target, r, p, lx, ly, cols, rows;
        bit paused;
        t_in_word w;
        paused = 1'b0;
        target = words_sent + count;
        while (words_sent < target) begin
            if (pause_midway && !paused && words_sent >= target - count / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            cols = sb.cols_now();
            rows = sb.rows_now();
            p = $urandom_range(sb.planes_now() - 1);
            lx = $urandom_range(cols - 1);
            ly = $urandom_range(rows - 1);
            r = $urandom_range(99);
            if (r < 50) begin
                if ($urandom_range(99) < 15)
                    send_write(p, lx + $urandom_range(1), ly + $urandom_range(1), $urandom);
                send_query(p, sb.org_x + lx, sb.org_y + ly, pick_frac(), pick_frac());
            end else if (r < 70) begin
                send_write(p, $urandom_range(cols), $urandom_range(rows), $urandom);
            end else if (r < 78) begin
                send_query(p, sb.org_x + lx, sb.org_y + ly,
                           $urandom_range(hbs_pkg::FRAC_ONE + 1, 8191), pick_frac());
            end else if (r < 90) begin
                case ($urandom_range(3))
                    0: send_query(p, sb.org_x - 1 - $urandom_range(3), sb.org_y + ly,
                                  pick_frac(), pick_frac());
                    1: send_query(p, sb.org_x + lx, sb.org_y + rows + $urandom_range(3),
                                  pick_frac(), pick_frac());
                    2: send_query($urandom_range(sb.planes_now(), 3), sb.org_x + lx,
                                  sb.org_y + ly, pick_frac(), pick_frac());
                    default: send_write(p, $urandom_range(cols + 1, 127), $urandom_range(127),
                                        $urandom);
                endcase
            end else begin
                w = {$urandom, $urandom, $urandom};
                w.pad = '0;
                if ($urandom_range(1))
                    send_query(w.plane, $signed(w.px), $signed(w.py), w.fx, w.fy);
                else
                    send_write(w.plane, w.sx, w.sy, w.value);
            end
        end
    endtask

    initial begin
        int errors;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 34;
        rx_idle_pct = 73;
        send_write(0, 0, 0, 32767);
        send_write(0, 1, 0, -32768);
        send_write(0, 0, 1, -32768);
        send_write(0, 1, 1, 32767);
        send_query(0, 0, 0, 0, 0);
        send_query(0, 0, 0, hbs_pkg::FRAC_ONE, hbs_pkg::FRAC_ONE);
        send_query(0, 0, 0, 2048, 4095);
        send_query(0, 0, 0, hbs_pkg::FRAC_ONE + 1, 0);
        send_query(1, -32768, 32767, 0, 8191);
        send_query(0, -1, 0, 0, 0);
        send_query(2, 0, 64, 100, 100);
        send_query(3, 32767, -32768, 0, 0);
        send_write(0, 65, 0, 1);
        send_write(1, 0, 127, 1);
        send_write(3, 63, 63, -1);
        send_write(3, 64, 63, 256);
        send_write(3, 63, 64, -256);
        send_write(3, 64, 64, 12345);
        send_query(3, 63, 63, hbs_pkg::FRAC_ONE, 0);
        send_query(3, 63, 63, 1, 4095);
        wait_for_results();

        load_geometry(-16384, 16383, 127, 1, 7);
        write_reg(CFG_SPARE, 16'h1234);
        run_random(150, 1'b1);
        wait_for_results();

        load_geometry(16383, -16384, 0, 64, 0);
        tx_idle_pct = 73;
        rx_idle_pct = 34;
        run_random(150, 1'b0);
        wait_for_results();

        load_geometry(-5, 3, 7, 5, 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(150, 1'b0);
        wait_for_results();

        errors = sb.mismatches;
        if (sb.pending() != 0) begin
            $display("ERROR: %0d result words never arrived", sb.pending());
            errors++;
        end
        $display("Sent %0d words (%0d sample writes) over four register settings; %0d checked.",
                 words_sent, writes_sent, sb.checked);
        $display("Status mix: ok %0d, outside %0d, fraction high %0d, corner outside %0d.",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
